// File: design/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude core.
// No dependencies; imported by the line RAM, the root unit and the top level.
`default_nettype none

package sgm_pkg;

    // Image geometry limits
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);
    localparam int COORD_W     = 10;
    localparam int SIZE_W      = 11;

    // Data widths
    localparam int PIXEL_W     = 8;
    localparam int GRAD_ABS_W  = 10;
    localparam int RADICAND_W  = 2 * GRAD_ABS_W + 1;
    localparam int ROOT_W      = 8;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Reset sizes and the minimum size
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;
    localparam logic [SIZE_W-1:0] MIN_SIZE     = 11'd3;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // One line store entry: the row two above and the row one above
    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_word_t;

endpackage

`default_nettype wire

// File: design/sgm_line_ram.sv
// Line store RAM: one entry per column holding the two previous rows.
// Single write port, single read port, registered read. Uses sgm_pkg.
`default_nettype none

module sgm_line_ram
    import sgm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [LINE_ADDR_W-1:0] wr_addr,
    input  wire line_word_t             wr_data,
    input  wire logic                   rd_en,
    input  wire logic [LINE_ADDR_W-1:0] rd_addr,
    output line_word_t                  rd_data
);

    line_word_t mem [MAX_WIDTH];
    line_word_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/sgm_isqrt.sv
// Iterative integer square root, one result bit per cycle, saturating at 255.
// Uses sgm_pkg for widths.
`default_nettype none

module sgm_isqrt
    import sgm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [RADICAND_W-1:0] radicand,
    output logic                       done,
    output logic [ROOT_W-1:0]          root
);

    localparam int BIT_W = $clog2(ROOT_W);
    localparam int SQ_W  = 2 * ROOT_W;

    logic                  active_reg;
    logic                  done_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQ_W-1:0]       rad_reg;
    logic [ROOT_W-1:0]     trial;
    logic [SQ_W-1:0]       trial_sq;

    // Trial root with the current bit set, and its square
    assign trial    = root_reg | (ROOT_W'(1) << bit_reg);
    assign trial_sq = trial * trial;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // anything at or above 256^2 saturates straight away
                if (radicand[RADICAND_W-1:SQ_W] != '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    active_reg <= 1'b1;
                    bit_reg    <= BIT_W'(ROOT_W - 1);
                end
            end
            else if (active_reg)
            begin
                if (bit_reg == '0)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand[SQ_W-1:0];
            if (radicand[RADICAND_W-1:SQ_W] != '0)
            begin
                root_reg <= '1;
            end
            else
            begin
                root_reg <= '0;
            end
        end
        else if (active_reg && (trial_sq <= rad_reg))
        begin
            root_reg <= trial;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: design/sobel_gradient_magnitude_core.sv
// Sobel 3x3 gradient magnitude core: window sequencer, gradient datapath and output register.
// Depends on sgm_pkg, sgm_line_ram and sgm_isqrt.
//
// Pixels enter in raster order, one beat each. The two previous rows live in a
// 1024-entry line RAM that is read when a pixel is taken and written back the
// next cycle. A pixel on the top two rows or left two columns only shifts the
// window and gives no result; any other pixel then passes through the gradient,
// squaring, bit-serial square root and done states (gradients whose squared sum
// reaches 65536 saturate to 255 and skip the root iterations), and waits in the
// done state until the output register frees up. The result waits in an output
// register, so the next pixel is taken while a result is stalled. Writing either
// size register restarts the frame at row 0, column 0; sizes are clamped to 3..1024.
`default_nettype none

module sobel_gradient_magnitude_core
    import sgm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]      cfg_data,
    // pixel input
    input  wire logic                   pixel_valid,
    output logic                        pixel_stall,
    input  wire logic [PIXEL_W-1:0]     pixel,
    // result output
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [ROOT_W-1:0]           magnitude,
    output logic [COORD_W-1:0]          center_col,
    output logic [COORD_W-1:0]          center_row,
    output logic                        frame_last
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_GRAD   = 3'd2;
    localparam logic [2:0] S_SQUARE = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);
    localparam int GRAD_W = GRAD_ABS_W + 1;

    logic [2:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   width_reg, height_reg;
    logic [SIZE_W-1:0]   width_eff, height_eff;
    logic [COORD_W-1:0]  col_reg, row_reg;
    logic [SIZE_W-1:0]   col_inc, row_inc;
    logic                pixel_beat, result_beat;

    // per-item captured state
    pixel_t              px_reg;
    logic [COORD_W-1:0]  cur_col_reg, cur_row_reg;
    logic                emit_reg, last_reg;

    pixel_t              win_reg [3][3];
    logic [GRAD_ABS_W-1:0] gx_abs_reg, gy_abs_reg;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [2*GRAD_ABS_W-1:0] gx_sq, gy_sq;
    logic [RADICAND_W-1:0] radicand;

    line_word_t          ram_rd_data, ram_wr_data;
    logic                root_done;
    logic [ROOT_W-1:0]   root;

    logic                out_valid_reg;
    logic [ROOT_W-1:0]   out_mag_reg;
    logic [COORD_W-1:0]  out_col_reg, out_row_reg;
    logic                out_last_reg;
    logic                out_load;

    // Effective frame size, clamped to 3..MAX
    always_comb
    begin
        if (width_reg < MIN_SIZE)
            width_eff = MIN_SIZE;
        else if (width_reg > MAX_W_SIZE)
            width_eff = MAX_W_SIZE;
        else
            width_eff = width_reg;
        if (height_reg < MIN_SIZE)
            height_eff = MIN_SIZE;
        else if (height_reg > MAX_H_SIZE)
            height_eff = MAX_H_SIZE;
        else
            height_eff = height_reg;
    end

    assign pixel_stall = (state_reg != S_IDLE);
    assign pixel_beat  = pixel_valid && !pixel_stall;
    assign result_beat = out_valid_reg && !result_stall;
    assign col_inc     = {1'b0, col_reg} + 1'b1;
    assign row_inc     = {1'b0, row_reg} + 1'b1;

    // Size registers and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pixel_beat)
        begin
            if (col_inc >= width_eff)
            begin
                col_reg <= '0;
                if (row_inc >= height_eff)
                    row_reg <= '0;
                else
                    row_reg <= row_inc[COORD_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COORD_W-1:0];
            end
        end
    end

    // Capture the pixel and its position
    always_ff @(posedge clk)
    begin
        if (pixel_beat)
        begin
            px_reg      <= pixel;
            cur_col_reg <= col_reg - 1'b1;
            cur_row_reg <= row_reg - 1'b1;
            emit_reg    <= (col_reg >= COORD_W'(2)) && (row_reg >= COORD_W'(2));
            last_reg    <= (col_inc == width_eff) && (row_inc == height_eff);
        end
    end

    // Line store: read on accept, write back the shifted column in the next cycle
    assign ram_wr_data.older = ram_rd_data.newer;
    assign ram_wr_data.newer = px_reg;

    sgm_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (state_reg == S_SHIFT),
        .wr_addr (cur_col_reg + 1'b1),
        .wr_data (ram_wr_data),
        .rd_en   (pixel_beat),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // 3x3 window slides left by one column per pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (state_reg == S_SHIFT)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= ram_rd_data.older;
            win_reg[1][2] <= ram_rd_data.newer;
            win_reg[2][2] <= px_reg;
        end
    end

    // Sobel kernels
    always_comb
    begin
        gx = (GRAD_W'(win_reg[0][2]) - GRAD_W'(win_reg[0][0]))
           + ((GRAD_W'(win_reg[1][2]) - GRAD_W'(win_reg[1][0])) <<< 1)
           + (GRAD_W'(win_reg[2][2]) - GRAD_W'(win_reg[2][0]));
        gy = (GRAD_W'(win_reg[2][0]) - GRAD_W'(win_reg[0][0]))
           + ((GRAD_W'(win_reg[2][1]) - GRAD_W'(win_reg[0][1])) <<< 1)
           + (GRAD_W'(win_reg[2][2]) - GRAD_W'(win_reg[0][2]));
    end

    // Absolute gradients
    always_ff @(posedge clk)
    begin
        if (state_reg == S_GRAD)
        begin
            gx_abs_reg <= gx[GRAD_W-1] ? GRAD_ABS_W'(-gx) : gx[GRAD_ABS_W-1:0];
            gy_abs_reg <= gy[GRAD_W-1] ? GRAD_ABS_W'(-gy) : gy[GRAD_ABS_W-1:0];
        end
    end

    // Sum of squares feeds the root unit
    assign gx_sq    = gx_abs_reg * gx_abs_reg;
    assign gy_sq    = gy_abs_reg * gy_abs_reg;
    assign radicand = {1'b0, gx_sq} + {1'b0, gy_sq};

    sgm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQUARE),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !result_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_beat)
                    state_next = S_SHIFT;
            end
            S_SHIFT:  state_next = emit_reg ? S_GRAD : S_IDLE;
            S_GRAD:   state_next = S_SQUARE;
            S_SQUARE: state_next = S_ROOT;
            S_ROOT:
            begin
                if (root_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result_beat)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mag_reg  <= root;
            out_col_reg  <= cur_col_reg;
            out_row_reg  <= cur_row_reg;
            out_last_reg <= last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign magnitude    = out_mag_reg;
    assign center_col   = out_col_reg;
    assign center_row   = out_row_reg;
    assign frame_last   = out_last_reg;

endmodule

`default_nettype wire

// File: tb/sobel_gradient_magnitude_core_tb.sv
// Self-checking testbench for the Sobel 3x3 gradient magnitude core. Depends on sgm_pkg and
// sobel_gradient_magnitude_core; predicts result beats in-line but for typed table rows.

module sobel_gradient_magnitude_core_tb;
    import sgm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int SMALL_PIXELS  = 60;
    localparam int PRINT_LIMIT   = 40;
    localparam int DIRECTED_ROWS = 20;

    typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_e;
    typedef enum int {PAT_UNIFORM, PAT_BINARY, PAT_SMOOTH} pattern_e;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [ROOT_W-1:0]  magnitude;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } edge_result_t;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [SIZE_W-1:0]      value;
        logic                   typed;
        edge_result_t           want;
    } stim_row_t;

    // DUT signals; the inputs are driven to known values from time zero
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [SIZE_W-1:0]      cfg_data     = '0;
    logic                   pixel_valid  = 1'b0;
    logic                   pixel_stall;
    logic [PIXEL_W-1:0]     pixel        = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [ROOT_W-1:0]      magnitude;
    logic [COORD_W-1:0]     center_col;
    logic [COORD_W-1:0]     center_row;
    logic                   frame_last;

    // Predictor state
    logic [SIZE_W-1:0] width_reg  = RESET_WIDTH;
    logic [SIZE_W-1:0] height_reg = RESET_HEIGHT;
    pixel_t            older_row [MAX_WIDTH];
    pixel_t            newer_row [MAX_WIDTH];
    pixel_t            win [3][3];
    int unsigned       col_pos = 0;
    int unsigned       row_pos = 0;

    edge_result_t expected_edges_q[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    // Directed frames: 3x3 with a saturating vertical edge, then a 3x3 with a
    // single bright corner (magnitude 1) reached through end-of-frame wrap.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  11'd3,   1'b0, '0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 11'd3,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd128, 1'b0, '0},
        '{ROW_PIXEL, '0,               11'd255, 1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd128, 1'b0, '0},
        '{ROW_PIXEL, '0,               11'd255, 1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd128, 1'b0, '0},
        '{ROW_PIXEL, '0,               11'd255, 1'b1, '{8'd255, 10'd1, 10'd1, 1'b1}},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd1,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b0, '0},
        '{ROW_PIXEL, '0,               11'd0,   1'b1, '{8'd1, 10'd1, 10'd1, 1'b1}}
    };

    sobel_gradient_magnitude_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .magnitude    (magnitude),
        .center_col   (center_col),
        .center_row   (center_row),
        .frame_last   (frame_last)
    );

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v, input int unsigned hi);
        if (v < MIN_SIZE)
            return 32'(MIN_SIZE);
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    // Advance the predicted image state by one pixel; returns 1 when a result is due.
    function automatic bit predict_sobel(input pixel_t px, output edge_result_t res);
        int unsigned w_eff, h_eff, c, r, idx;
        int          gx, gy, sq, root, i;
        w_eff = clamp_dim(width_reg, MAX_WIDTH);
        h_eff = clamp_dim(height_reg, MAX_HEIGHT);
        c     = col_pos;
        r     = row_pos;
        idx   = c % MAX_WIDTH;
        res   = '0;

        // slide the window and pull in the new column from the line stores
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]      = older_row[idx];
        win[1][2]      = newer_row[idx];
        win[2][2]      = px;
        older_row[idx] = newer_row[idx];
        newer_row[idx] = px;

        // raster position, wraps at end of frame
        if (c + 1 >= w_eff)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h_eff) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;

        // border pixels give no result
        if (c < 2 || r < 2)
            return 1'b0;

        gx = (int'(win[0][2]) - int'(win[0][0])) + 2 * (int'(win[1][2]) - int'(win[1][0]))
           + (int'(win[2][2]) - int'(win[2][0]));
        gy = (int'(win[2][0]) - int'(win[0][0])) + 2 * (int'(win[2][1]) - int'(win[0][1]))
           + (int'(win[2][2]) - int'(win[0][2]));
        sq = gx * gx + gy * gy;

        // floored root, saturates once the root would reach 256
        if (sq >= 65536)
            root = 255;
        else
        begin
            root = 0;
            while ((root + 1) * (root + 1) <= sq)
                root++;
        end

        res.magnitude = root[ROOT_W-1:0];
        res.col       = COORD_W'(c - 1);
        res.row       = COORD_W'(r - 1);
        res.last      = (c == w_eff - 1) && (r == h_eff - 1);
        return 1'b1;
    endfunction

    task automatic set_idle(input idle_mode_e m);
        case (m)
            IDLE_SEND:
            begin
                send_idle_pct = 73;
                recv_stall_pct <= 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 73;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = 17;
                recv_stall_pct <= 17;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
        endcase
    endtask

    // One pixel beat; valid stays high into the next beat unless a gap is drawn
    task automatic send_pixel(input pixel_t px, input logic typed, input edge_result_t want);
        edge_result_t predicted;
        bit           emits;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do @(posedge clk); while (pixel_stall);
        emits = predict_sobel(px, predicted);
        if (typed)
            expected_edges_q.push_back(want);
        else if (emits)
            expected_edges_q.push_back(predicted);
    endtask

    task automatic wait_for_results();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (expected_edges_q.size() != 0);
    endtask

    // Register write once the core has gone quiet
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        col_pos = 0;
        row_pos = 0;
    endtask

    // which: 0 writes both sizes, 1 width only, 2 height only; n_req 0 picks a random count
    task automatic run_phase(input int ph, input logic [SIZE_W-1:0] w_val,
                             input logic [SIZE_W-1:0] h_val, input int which,
                             input int n_req, input pattern_e pat, output int n_sent);
        int     frame, n, k, level, step;
        pixel_t px;
        if (which != 2)
            write_reg(CFG_IMAGE_WIDTH, w_val);
        if (which != 1)
            write_reg(CFG_IMAGE_HEIGHT, h_val);
        frame = clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
        n     = n_req;
        if (n == 0)
        begin
            n = frame * $urandom_range(1, 2);
            // often stop mid-frame so the next write restarts a partial frame
            if ($urandom_range(1))
                n += $urandom_range(frame - 1);
            if (n > 400)
                n = 400;
        end
        set_idle(idle_mode_e'(ph % 4));
        level = $urandom_range(255);
        step  = $urandom_range(1, 48);
        for (k = 0; k < n; k++)
        begin
            // hold off the sender until all pending results are out
            if (k == n / 2 && ph % 3 == 0)
                wait_for_results();
            case (pat)
                PAT_BINARY:
                    px = $urandom_range(1) ? 8'hFF : 8'h00;
                PAT_SMOOTH:
                begin
                    level = level + int'($urandom_range(2 * step)) - step;
                    if (level < 0)
                        level = 0;
                    else if (level > 255)
                        level = 255;
                    px = pixel_t'(level);
                end
                default:
                    px = pixel_t'($urandom_range(255));
            endcase
            send_pixel(px, 1'b0, '0);
        end
        n_sent = n;
    endtask

    // Result monitor and receiver stall
    always @(posedge clk)
    begin : result_monitor
        edge_result_t exp_beat;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_edges_q.size() == 0)
                report_mismatch($sformatf("unexpected result beat col %0d row %0d",
                                          center_col, center_row));
            else
            begin
                exp_beat = expected_edges_q.pop_front();
                if (magnitude !== exp_beat.magnitude)
                    report_mismatch($sformatf("magnitude got %0d expected %0d (col %0d row %0d)",
                                              magnitude, exp_beat.magnitude,
                                              exp_beat.col, exp_beat.row));
                if (center_col !== exp_beat.col)
                    report_mismatch($sformatf("center_col got %0d expected %0d",
                                              center_col, exp_beat.col));
                if (center_row !== exp_beat.row)
                    report_mismatch($sformatf("center_row got %0d expected %0d",
                                              center_row, exp_beat.row));
                if (frame_last !== exp_beat.last)
                    report_mismatch($sformatf("frame_last got %0b expected %0b (col %0d row %0d)",
                                              frame_last, exp_beat.last,
                                              exp_beat.col, exp_beat.row));
            end
        end
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Main sequence
    initial
    begin
        int           i, ph, n_sent, small_total, which;
        logic [SIZE_W-1:0] w_val, h_val;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (i = 0; i < 9; i++)
            win[i / 3][i % 3] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        set_idle(IDLE_NONE);
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].value);
            else
                send_pixel(directed_rows[i].value[PIXEL_W-1:0], directed_rows[i].typed,
                           directed_rows[i].want);
        end

        // widest line, tallest frame (clamped), then sizes below the minimum
        run_phase(0, 11'd1024, 11'd3, 0, 2 * MAX_WIDTH + 12, PAT_SMOOTH, n_sent);
        run_phase(1, 11'd3, 11'd2047, 0, 40, PAT_UNIFORM, n_sent);
        run_phase(2, 11'd0, 11'd1, 0, 0, PAT_BINARY, n_sent);

        // random small frames, mostly tiny sizes
        small_total = 0;
        ph          = 3;
        while (small_total < SMALL_PIXELS)
        begin
            w_val = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(13, 40))
                                             : SIZE_W'($urandom_range(0, 12));
            h_val = ($urandom_range(3) == 0) ? SIZE_W'($urandom_range(9, 20))
                                             : SIZE_W'($urandom_range(0, 8));
            which = (ph < 6) ? 0 : $urandom_range(2);
            run_phase(ph, w_val, h_val, which, 0, pattern_e'($urandom_range(2)), n_sent);
            small_total += n_sent;
            ph++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
